[rtl/core/bfa_pkg.sv]
// Shared types and constants for the bitmap frame allocator.
// Holds the request and response payload structs and the operation codes.
// No dependencies.
`default_nettype none

package bfa_pkg;

  // Width of a frame field in a page entry.
  localparam int FRAME_W = 12;

  // Number of physical frames that the bitmap covers; every frame number
  // must fit in a frame field.
  localparam int NUM_FRAMES = 4096;

  // Width and reset value of the frame count register.
  localparam int FC_W = 13;
  localparam logic [FC_W-1:0] FC_RESET = 13'd4096;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [FRAME_W-1:0] current_frame;
    logic               kernel_page;
    logic               write_allowed;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               present_out;
    logic               writable_out;
    logic               user_out;
    logic               changed;
    logic               full_res;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/core/bitmap_frame_allocator.sv]
// Top level of the first-fit bitmap allocator of physical page frames.
// Depends on bfa_pkg for the payload structs, operation codes, the number of
// frames and the frame count register's width and reset value.
//
//   Channel   Direction  Handshake              Payload
//   in_*      input      in_valid / in_stall    bfa_pkg::req_t
//   out_*     output     out_valid / out_stall  bfa_pkg::rsp_t
//   cfg_*     input      cfg_wr_en              frame_count, 13 bits
//
// After reset the bitmap's bfa_pkg::NUM_FRAMES/WORD_BITS words (128 with the defaults)
// are cleared one word per cycle, and no request is taken meanwhile. A request is
// taken only while the sequencer is idle. A free inside the bitmap passes through the
// divide, read and write states before its result, and a request that needs no bitmap
// access goes straight to its result. A fresh allocation divides, then reads and checks
// the words up to the first with a clear bit; a stalled result holds the next one back.
`default_nettype none

module bitmap_frame_allocator #(
  parameter int WORD_BITS  = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,

  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bfa_pkg::req_t in_data,

  output logic               out_valid,
  input  wire logic          out_stall,
  output bfa_pkg::rsp_t      out_data,

  input  wire logic          cfg_wr_en,
  input  wire logic [bfa_pkg::FC_W-1:0] cfg_wr_data
);

  // Bitmap geometry. The memory always has at least one word so that its
  // address is well formed, but only MAP_WORDS words ever take part.
  localparam int MAP_WORDS = bfa_pkg::NUM_FRAMES / WORD_BITS;
  localparam int MEM_DEPTH = (MAP_WORDS > 0) ? MAP_WORDS : 1;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int BW        = $clog2(WORD_BITS);

  // Division by WORD_BITS is done by multiplying with a rounded-up
  // reciprocal, which is exact for every dividend below 2**DIV_N.
  localparam int DIV_N  = bfa_pkg::FC_W;
  localparam int DIV_L  = $clog2(WORD_BITS);
  localparam int DIV_SH = DIV_N + DIV_L;
  localparam int DIV_M  = (2 ** DIV_SH + WORD_BITS - 1) / WORD_BITS;
  localparam int DIV_MW = DIV_N + 2;
  localparam int DIV_PW = DIV_N + DIV_MW;

  // The word counter must reach both the memory depth and any quotient.
  localparam int CW = ((AW + 1) > DIV_N) ? (AW + 1) : DIV_N;
  // Width in which a frame number is formed before it is cut to 12 bits.
  localparam int PW = CW + BW + 1;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_FREE_RD = 3'd3;
  localparam logic [2:0] ST_FREE_WR = 3'd4;
  localparam logic [2:0] ST_SCAN    = 3'd5;
  localparam logic [2:0] ST_CHECK   = 3'd6;
  localparam logic [2:0] ST_RESP    = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [bfa_pkg::FC_W-1:0] frame_count_r;
  bfa_pkg::req_t            req_r, req_nxt;
  bfa_pkg::rsp_t            res_r, res_nxt;
  bfa_pkg::rsp_t            out_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [DIV_N-1:0]         q_r, q_nxt;
  logic [BW-1:0]            bit_r, bit_nxt;

  // Bitmap memory, one port each for read and write, read data registered.
  logic [WORD_BITS-1:0]     bitmap_mem [MEM_DEPTH];
  logic [WORD_BITS-1:0]     rd_data_r;
  logic                     mem_rd_en;
  logic [AW-1:0]            mem_rd_addr;
  logic                     mem_wr_en;
  logic [AW-1:0]            mem_wr_addr;
  logic [WORD_BITS-1:0]     mem_wr_data;

  // Shared divider datapath.
  logic [DIV_N-1:0]         div_in;
  logic [DIV_PW-1:0]        div_prod;

  // Remainder and word-count helpers.
  logic [DIV_N-1:0]         rem_full;
  logic [CW-1:0]            q_ext;

  // Lowest clear bit of the word just read.
  logic [WORD_BITS-1:0]     inv_word;
  logic [WORD_BITS-1:0]     low_bit;
  logic [BW-1:0]            low_idx;
  logic [PW-1:0]            picked_frame;
  logic                     word_full;

  logic                     in_xfer;
  logic                     out_xfer;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The divider serves both the free (frame to word) and the allocate
  // (frame count to word limit) paths; the operation picks its operand.
  assign div_in   = (req_r.operation == bfa_pkg::OP_FREE) ?
                    DIV_N'(req_r.current_frame) : frame_count_r;
  assign div_prod = DIV_PW'(div_in) * DIV_PW'(DIV_M);

  assign rem_full = DIV_N'(req_r.current_frame) - DIV_N'(q_r * DIV_N'(WORD_BITS));
  assign q_ext    = CW'(q_r);

  // Isolate the lowest zero of the word: invert, then keep the lowest one.
  assign inv_word  = ~rd_data_r;
  assign low_bit   = inv_word & (~inv_word + WORD_BITS'(1));
  assign word_full = (inv_word == '0);

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | BW'(i);
      end
    end
  end

  assign picked_frame = PW'(idx_r) * PW'(WORD_BITS) + PW'(low_idx);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    idx_nxt       = idx_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = idx_r[AW-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = idx_r[AW-1:0];
    mem_wr_data   = '0;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
        if (idx_r == CW'(MEM_DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          req_nxt = in_data;
          res_nxt = '0;
          idx_nxt = '0;
          if (in_data.current_frame == '0) begin
            if (in_data.operation == bfa_pkg::OP_FREE) begin
              // Nothing to free: the entry stays empty.
              state_nxt = ST_RESP;
            end else begin
              state_nxt = ST_DIV;
            end
          end else if (in_data.operation == bfa_pkg::OP_FREE) begin
            state_nxt = ST_DIV;
          end else begin
            // The entry already holds a frame and is handed back as it was.
            res_nxt.frame_out = in_data.current_frame;
            state_nxt         = ST_RESP;
          end
        end
      end

      ST_DIV: begin
        q_nxt = DIV_N'(div_prod >> DIV_SH);
        if (req_r.operation == bfa_pkg::OP_FREE) begin
          state_nxt = ST_FREE_RD;
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_FREE_RD: begin
        bit_nxt = rem_full[BW-1:0];
        res_nxt.changed = 1'b1;
        if (q_ext < CW'(MAP_WORDS)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = q_ext[AW-1:0];
          state_nxt   = ST_FREE_WR;
        end else begin
          // Outside the bitmap: only the entry is cleared.
          state_nxt = ST_RESP;
        end
      end

      ST_FREE_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = q_ext[AW-1:0];
        mem_wr_data = rd_data_r & ~(WORD_BITS'(1) << bit_r);
        state_nxt   = ST_RESP;
      end

      ST_SCAN: begin
        if ((idx_r < q_ext) && (idx_r < CW'(MAP_WORDS))) begin
          mem_rd_en = 1'b1;
          state_nxt = ST_CHECK;
        end else begin
          res_nxt.full_res = 1'b1;
          state_nxt        = ST_RESP;
        end
      end

      ST_CHECK: begin
        if (word_full) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_SCAN;
        end else begin
          mem_wr_en            = 1'b1;
          mem_wr_data          = rd_data_r | low_bit;
          res_nxt.frame_out    = picked_frame[bfa_pkg::FRAME_W-1:0];
          res_nxt.present_out  = 1'b1;
          res_nxt.writable_out = req_r.write_allowed;
          res_nxt.user_out     = ~req_r.kernel_page;
          res_nxt.changed      = 1'b1;
          state_nxt            = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
      frame_count_r <= bfa_pkg::FC_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        frame_count_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
    q_r   <= q_nxt;
    bit_r <= bit_nxt;
    if ((state_r == ST_RESP) && (!out_valid_r || !out_stall)) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_data_r <= bitmap_mem[mem_rd_addr];
    end
    if (mem_wr_en) begin
      bitmap_mem[mem_wr_addr] <= mem_wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bfa_checker.sv]
// Port-level checks for the bitmap frame allocator, bound to its top level.
// Depends on bfa_pkg for the payload structs.
`default_nettype none

module bfa_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire bfa_pkg::req_t in_data,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire bfa_pkg::rsp_t out_data
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was withdrawn");

  // One request at a time: the block is busy right after a transfer in.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while a previous one is in progress");

  // A new result only appears after the block has been busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

  // A fresh allocation always marks the entry changed and never reports full.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.present_out |-> out_data.changed && !out_data.full_res)
    else $error("allocation result has inconsistent flags");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_frame_allocator: a directed table, then random phases.
// Depends on bfa_pkg for the request and response structs, operation codes and register width.

module testbench;
  import bfa_pkg::*;

  localparam int MAP_WORDS   = 128;
  localparam int WORD_BITS   = 32;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYC  = 8;
  localparam int TAIL_CYC    = 20;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 105;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  req_t            in_data;
  logic            out_valid;
  logic            out_stall;
  rsp_t            out_data;
  logic            cfg_wr_en;
  logic [FC_W-1:0] cfg_wr_data;

  bitmap_frame_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // One row of the directed table. A row either rewrites the frame count or
  // carries a request; where the answer is obvious it is typed in directly.
  typedef struct {
    bit              is_cfg;
    logic [FC_W-1:0] cfg_val;
    req_t            req;
    bit              typed;
    rsp_t            want;
  } dir_row_t;

  // The testbench's own copy of the allocator state: the frame bitmap and the
  // frame count register.
  logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
  logic [FC_W-1:0]      frame_count_q;

  rsp_t            expected_q [$];
  logic [FRAME_W-1:0] held_frames [$];
  dir_row_t        dir_tab [$];

  int  cycle_cnt;
  int  errors;
  int  items_sent;
  int  results_seen;
  int  refusals;
  int  settings_used;
  bit  calm;

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Watchdog: a correct run finishes far inside the cycle limit.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // The receiver stalls about 15 percent of the time, except during the
  // calm stretch. It changes only on the falling edge.
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < 15);
    end
  end

  function automatic rsp_t mk_rsp(int frame, bit p, bit w, bit u, bit ch, bit full);
    rsp_t r;
    r.frame_out    = FRAME_W'(frame);
    r.present_out  = p;
    r.writable_out = w;
    r.user_out     = u;
    r.changed      = ch;
    r.full_res     = full;
    return r;
  endfunction

  function automatic req_t mk_req(logic op, int cur, bit kern, bit wr);
    req_t r;
    r.operation     = op;
    r.current_frame = FRAME_W'(cur);
    r.kernel_page   = kern;
    r.write_allowed = wr;
    return r;
  endfunction

  function automatic dir_row_t req_row(req_t r, bit typed, rsp_t want);
    dir_row_t d;
    d.is_cfg  = 1'b0;
    d.cfg_val = '0;
    d.req     = r;
    d.typed   = typed;
    d.want    = want;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(int v);
    dir_row_t d;
    d.is_cfg  = 1'b1;
    d.cfg_val = FC_W'(v);
    d.req     = '0;
    d.typed   = 1'b0;
    d.want    = '0;
    return d;
  endfunction

  // Computes the page entry that a request leaves behind and updates the
  // bitmap copy to match. Allocation is first fit over the whole words that
  // the frame count covers, capped at the depth of the bitmap.
  function automatic rsp_t predict_entry(req_t r);
    rsp_t o;
    int   words;
    int   w;
    int   b;
    bit   found;
    o = '0;
    if (r.operation == OP_FREE) begin
      // A free of an empty entry changes nothing; any other free clears the
      // frame's bit, whether or not it lies inside the frame count.
      if (r.current_frame != '0) begin
        frame_map[r.current_frame / WORD_BITS][r.current_frame % WORD_BITS] = 1'b0;
        o.changed = 1'b1;
      end
    end else if (r.current_frame != '0) begin
      // The entry already holds a frame, so it comes back as it was.
      o.frame_out = r.current_frame;
    end else begin
      words = int'(frame_count_q) / WORD_BITS;
      if (words > MAP_WORDS) words = MAP_WORDS;
      found = 1'b0;
      for (w = 0; w < words && !found; w++) begin
        if (frame_map[w] != '1) begin
          for (b = 0; b < WORD_BITS && !found; b++) begin
            if (!frame_map[w][b]) begin
              frame_map[w][b] = 1'b1;
              o.frame_out     = FRAME_W'(w * WORD_BITS + b);
              o.present_out   = 1'b1;
              o.writable_out  = r.write_allowed;
              o.user_out      = !r.kernel_page;
              o.changed       = 1'b1;
              found           = 1'b1;
            end
          end
        end
      end
      if (!found) o.full_res = 1'b1;
    end
    return o;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 40) $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_field(string name, int got, int want, int idx);
    if (got != want)
      note_error($sformatf("result %0d field %s is %0d, expected %0d", idx, name, got, want));
  endtask

  // Offers one request, with a random idle gap in front of it, and holds it
  // until the transfer takes place. The expectation is queued at that edge.
  task automatic send_req(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_entry(r);
    if (pred.present_out) held_frames.push_back(pred.frame_out);
    if (pred.full_res) refusals++;
    expected_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Drops valid and waits until every outstanding result has been taken.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Rewrites the frame count once the allocator has nothing in flight.
  task automatic write_frame_count(input logic [FC_W-1:0] v);
    drain();
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    frame_count_q = v;
    settings_used++;
  endtask

  // Random request mix: mostly fresh allocations and frees of frames that
  // are really held, with some entries that already hold a frame and some
  // frees of arbitrary frames, zero included.
  task automatic send_random;
    req_t r;
    int   p;
    int   idx;
    p = $urandom_range(99);
    r = mk_req(OP_ALLOC, 0, $urandom_range(1), $urandom_range(1));
    if (p >= 55 && p < 80) begin
      r.operation = OP_FREE;
      if (held_frames.size() != 0) begin
        idx = $urandom_range(held_frames.size() - 1);
        r.current_frame = held_frames[idx];
        held_frames.delete(idx);
      end else begin
        r.current_frame = FRAME_W'($urandom_range(4095));
      end
    end else if (p >= 80 && p < 90) begin
      r.current_frame = FRAME_W'($urandom_range(4095, 1));
    end else if (p >= 90) begin
      r.operation     = OP_FREE;
      r.current_frame = FRAME_W'($urandom);
    end
    send_req(r, 1'b0, '0);
  endtask

  function automatic logic [FC_W-1:0] fc_for_phase(int ph);
    case (ph)
      0:       return FC_RESET;
      1:       return FC_W'(32);
      2:       return '1;
      3:       return '0;
      4:       return FC_W'(64);
      5:       return FC_W'(1000);
      6:       return FC_RESET;
      7:       return FC_W'(33);
      8:       return '1;
      default: return FC_W'($urandom_range(8191));
    endcase
  endfunction

  // Result monitor: every transfer on the result channel is matched against
  // the oldest expectation, field by field.
  always @(posedge clk) begin : result_monitor
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        note_error("result transfer with nothing outstanding");
      end else begin
        want = expected_q.pop_front();
        check_field("frame_out",    out_data.frame_out,    want.frame_out,    results_seen);
        check_field("present_out",  out_data.present_out,  want.present_out,  results_seen);
        check_field("writable_out", out_data.writable_out, want.writable_out, results_seen);
        check_field("user_out",     out_data.user_out,     want.user_out,     results_seen);
        check_field("changed",      out_data.changed,      want.changed,      results_seen);
        check_field("full_res",     out_data.full_res,     want.full_res,     results_seen);
        results_seen++;
      end
    end
  end

  initial begin : stimulus
    int i;
    int ph;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    calm          = 1'b0;
    cycle_cnt     = 0;
    errors        = 0;
    items_sent    = 0;
    results_seen  = 0;
    refusals      = 0;
    settings_used = 0;
    frame_count_q = FC_RESET;
    for (i = 0; i < MAP_WORDS; i++) frame_map[i] = '0;

    // Directed table. With the bitmap empty after reset, frame zero is the
    // first to be handed out, and is an ordinary frame.
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 0, 1), 1, mk_rsp(0, 1, 1, 1, 1, 0)));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 1, 0), 1, mk_rsp(1, 1, 0, 0, 1, 0)));
    // Entries that already hold a frame come back untouched.
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 4095, 1, 1), 1, mk_rsp(4095, 0, 0, 0, 0, 0)));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 2730, 0, 0), 1, mk_rsp(2730, 0, 0, 0, 0, 0)));
    // A free of an empty entry does nothing; any other free clears it.
    dir_tab.push_back(req_row(mk_req(OP_FREE, 0, 1, 1), 1, mk_rsp(0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(req_row(mk_req(OP_FREE, 1, 0, 0), 1, mk_rsp(0, 0, 0, 0, 1, 0)));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 0, 0), 0, '0));
    dir_tab.push_back(req_row(mk_req(OP_FREE, 4095, 1, 0), 1, mk_rsp(0, 0, 0, 0, 1, 0)));
    dir_tab.push_back(req_row(mk_req(OP_FREE, 1365, 0, 1), 1, mk_rsp(0, 0, 0, 0, 1, 0)));
    // No whole word to search: every fresh allocation is refused as full.
    dir_tab.push_back(cfg_row(0));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 0, 1), 1, mk_rsp(0, 0, 0, 0, 0, 1)));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 5, 1, 1), 1, mk_rsp(5, 0, 0, 0, 0, 0)));
    dir_tab.push_back(req_row(mk_req(OP_FREE, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0)));
    dir_tab.push_back(cfg_row(31));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 1, 0), 1, mk_rsp(0, 0, 0, 0, 0, 1)));
    // A count beyond the bitmap saturates at its depth.
    dir_tab.push_back(cfg_row(8191));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 1, 1), 0, '0));
    dir_tab.push_back(req_row(mk_req(OP_FREE, 2, 1, 1), 1, mk_rsp(0, 0, 0, 0, 1, 0)));
    dir_tab.push_back(cfg_row(33));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 0, 1), 0, '0));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 1, 0), 0, '0));
    dir_tab.push_back(cfg_row(4096));
    dir_tab.push_back(req_row(mk_req(OP_ALLOC, 0, 0, 0), 0, '0));

    // Hold reset, then release it. The bitmap clearing pass that follows is covered
    // by the input handshake, which simply waits for it.
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].is_cfg) write_frame_count(dir_tab[i].cfg_val);
      else send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases, each under its own frame count. The bitmap carries over
    // from phase to phase, so frames held beyond a lowered count get freed
    // and handed out again later. The fifth phase runs with no idling.
    for (ph = 0; ph < PHASES; ph++) begin
      write_frame_count(fc_for_phase(ph));
      calm = (ph == 4);
      repeat (PHASE_ITEMS) send_random();
      calm = 1'b0;
    end

    drain();
    repeat (TAIL_CYC) @(posedge clk);

    $display("Covered %0d requests over %0d frame-count settings, %0d results checked.",
             items_sent, settings_used, results_seen);
    $display("Allocations refused as full: %0d; frames still held: %0d.",
             refusals, held_frames.size());
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      if (expected_q.size() != 0)
        $display("ERROR: %0d expected results never arrived", expected_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bfa_pkg.sv
rtl/core/bitmap_frame_allocator.sv
rtl/core/bfa_checker.sv
tb/testbench.sv
